// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle as its trigger.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Property whose consequence must hold in the cycle after its trigger.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/kdee_pkg.sv -----
// ----------------------------------------------------------------------------
// kdee_pkg
// Shared codes and constants of the key debounce and event engine.
// ----------------------------------------------------------------------------
`default_nettype none

package kdee_pkg;

   // Commands carried on the request tuser field.
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_PAUSE = 2'd1,
      CMD_KILL  = 2'd2
   } cmd_type;

   // Event codes carried on the response tuser field.
   typedef enum logic [2:0] {
      EV_NONE   = 3'd0,
      EV_BREAK  = 3'd1,
      EV_FIRST  = 3'd2,
      EV_LONG   = 3'd3,
      EV_REPEAT = 3'd4
   } event_type;

   // Per-key phase machine, kept one-hot in the state memory.
   typedef enum logic [5:0] {
      PH_OFF    = 6'b000001,
      PH_START  = 6'b000010,
      PH_DELAY  = 6'b000100,
      PH_REPEAT = 6'b001000,
      PH_PAUSE  = 6'b010000,
      PH_KILLED = 6'b100000
   } phase_type;

   // Configuration register indexes.
   localparam logic [1:0] REG_LONG_PRESS   = 2'd0;
   localparam logic [1:0] REG_REPEAT_DELAY = 2'd1;
   localparam logic [1:0] REG_REPEAT_STEP  = 2'd2;
   localparam logic [1:0] REG_PAUSE        = 2'd3;

   // Configuration reset values.
   localparam logic [7:0] LONG_PRESS_RESET   = 8'd32;
   localparam logic [7:0] REPEAT_DELAY_RESET = 8'd40;
   localparam logic [7:0] REPEAT_STEP_RESET  = 8'd48;
   localparam logic [7:0] PAUSE_RESET        = 8'd64;

   // Repeat intervals in ticks.
   localparam logic [4:0] IV_START = 5'd16;
   localparam logic [4:0] IV_PAUSE = 5'd8;

endpackage

`default_nettype wire

// ----- hw/rtl/kdee_ram.sv -----
// ----------------------------------------------------------------------------
// kdee_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module kdee_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/key_debounce_event_engine.sv -----
// ----------------------------------------------------------------------------
// key_debounce_event_engine
// Per-key debounce, press, long-press and auto-repeat event generation.
// ----------------------------------------------------------------------------
// Usage: each request word addresses one key slot. Its tuser holds the
// command (tick with a raw sample, pause, kill) and its tdata holds the key
// index and the raw sample. Every request produces exactly one response word
// carrying the event code in tuser and the key index and debounced level in
// tdata. The csr port writes the four tick thresholds and should only be used
// while no request is in flight.
// A request goes through the compute stage and response registers before its
// response word turns valid. One word per cycle is sustained while the
// receiver keeps rsp_tready high: the state memory is read in the accept
// cycle and written back from the compute stage, and a write that overlaps
// the read of the same key is forwarded from a bypass register.
// After reset every key reads as released and off with an interval of
// sixteen; per-key valid bits stand in for the memory contents until a key is
// first written, so no clearing pass is needed. When the receiver stalls,
// the response register holds its word, the compute stage holds one more,
// and req_tready drops until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module key_debounce_event_engine #(
   parameter int KEY_SLOTS    = 16,
   parameter int HISTORY_BITS = 4
) (
   input  logic       clock,
   input  logic       reset,
   // Request channel.
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [3:0] key_index, [4] pressed, [7:5] zero
   input  logic [1:0] req_tuser,   // [1:0] command
   // Response channel.
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [3:0] event_key, [4] debounced_level, [7:5] zero
   output logic [2:0] rsp_tuser,   // [2:0] event_kind
   // Configuration write port.
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   localparam int ADDR_W = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

   // One state memory record per key.
   typedef struct packed {
      logic [HISTORY_BITS-1:0] hist;
      logic [7:0]              count;
      kdee_pkg::phase_type     phase;
      logic [4:0]              interval;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   localparam rec_type RESET_REC = '{
      hist:     '0,
      count:    8'd0,
      phase:    kdee_pkg::PH_OFF,
      interval: kdee_pkg::IV_START
   };

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [7:0] long_press_ff;
   logic [7:0] repeat_delay_ff;
   logic [7:0] repeat_step_ff;
   logic [7:0] pause_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff   <= kdee_pkg::LONG_PRESS_RESET;
         repeat_delay_ff <= kdee_pkg::REPEAT_DELAY_RESET;
         repeat_step_ff  <= kdee_pkg::REPEAT_STEP_RESET;
         pause_ff        <= kdee_pkg::PAUSE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            kdee_pkg::REG_LONG_PRESS:   long_press_ff   <= csr_wdata;
            kdee_pkg::REG_REPEAT_DELAY: repeat_delay_ff <= csr_wdata;
            kdee_pkg::REG_REPEAT_STEP:  repeat_step_ff  <= csr_wdata;
            kdee_pkg::REG_PAUSE:        pause_ff        <= csr_wdata;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Accept stage: decode the request and issue the memory read.
   // ------------------------------------------------------------------
   logic [3:0]          req_key;
   logic [ADDR_W+3:0]   req_key_wide;
   logic [ADDR_W-1:0]   req_addr;
   logic                req_in_range;
   logic                req_fire;

   assign req_key      = req_tdata[3:0];
   assign req_key_wide = {{ADDR_W{1'b0}}, req_key};
   assign req_addr     = req_key_wide[ADDR_W-1:0];
   assign req_in_range = ({5'd0, req_key} < 9'(KEY_SLOTS));
   assign req_fire     = req_tvalid && req_tready;

   // Compute stage registers.
   logic                s1_valid_ff;
   logic [3:0]          s1_key_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic                s1_in_range_ff;
   logic [1:0]          s1_cmd_ff;
   logic                s1_sample_ff;
   logic                s1_fwd_hit_ff;
   rec_type             fwd_rec_ff;
   logic [KEY_SLOTS-1:0] valid_ff;

   // Response register.
   logic                rsp_valid_ff;
   kdee_pkg::event_type rsp_kind_ff;
   logic [3:0]          rsp_key_ff;
   logic                rsp_level_ff;

   logic                s1_advance;
   logic                s1_fire;

   assign s1_advance = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && s1_advance;
   assign req_tready = !s1_valid_ff || s1_advance;

   // ------------------------------------------------------------------
   // State memory.
   // ------------------------------------------------------------------
   logic              ram_we;
   logic [REC_W-1:0]  ram_rd_data;
   rec_type           nxt_rec;

   kdee_ram #(
      .WIDTH (REC_W),
      .DEPTH (KEY_SLOTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_addr_ff),
      .wr_data (nxt_rec),
      .rd_en   (req_fire),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // ------------------------------------------------------------------
   // Compute stage: pick the current record and run the key phase machine.
   // A read issued in the same cycle as a write to the same key returns
   // stale data, so that case takes the bypass register instead. Keys that
   // were never written read as the reset record through their valid bit.
   // ------------------------------------------------------------------
   rec_type             cur_rec;
   kdee_pkg::event_type ev;
   logic                level;

   always_comb begin
      logic [HISTORY_BITS-1:0] h;
      logic [7:0]              cnt;
      kdee_pkg::phase_type     ph;
      logic [4:0]              iv;

      if (s1_fwd_hit_ff) begin
         cur_rec = fwd_rec_ff;
      end else if (valid_ff[s1_addr_ff]) begin
         cur_rec = rec_type'(ram_rd_data);
      end else begin
         cur_rec = RESET_REC;
      end

      nxt_rec = cur_rec;
      ev      = kdee_pkg::EV_NONE;
      h       = HISTORY_BITS'({cur_rec.hist, s1_sample_ff});
      cnt     = cur_rec.count + 8'd1;
      ph      = cur_rec.phase;
      iv      = cur_rec.interval;

      unique case (kdee_pkg::cmd_type'(s1_cmd_ff))
         kdee_pkg::CMD_TICK: begin
            // A fully released history ends any active phase.
            if (ph != kdee_pkg::PH_OFF && h == '0) begin
               if (ph != kdee_pkg::PH_KILLED) begin
                  ev = kdee_pkg::EV_BREAK;
               end
               cnt = 8'd0;
               ph  = kdee_pkg::PH_OFF;
            end
            unique case (ph)
               kdee_pkg::PH_OFF: begin
                  if (h == '1) begin
                     ph  = kdee_pkg::PH_START;
                     cnt = 8'd0;
                  end
               end
               kdee_pkg::PH_START: begin
                  ev  = kdee_pkg::EV_FIRST;
                  ph  = kdee_pkg::PH_DELAY;
                  cnt = 8'd0;
               end
               kdee_pkg::PH_DELAY: begin
                  if (cnt == long_press_ff) begin
                     ev = kdee_pkg::EV_LONG;
                  end
                  if (cnt == repeat_delay_ff) begin
                     ph  = kdee_pkg::PH_REPEAT;
                     iv  = kdee_pkg::IV_START;
                     cnt = 8'd0;
                  end
               end
               kdee_pkg::PH_REPEAT: begin
                  if (iv == 5'd0) begin
                     iv = 5'd1;
                  end
                  // Halve the interval once each step period has passed.
                  if (iv > 5'd1 && cnt >= repeat_step_ff) begin
                     iv  = iv >> 1;
                     cnt = 8'd0;
                  end
                  if ((cnt & {3'd0, iv - 5'd1}) == 8'd0) begin
                     ev = kdee_pkg::EV_REPEAT;
                  end
               end
               kdee_pkg::PH_PAUSE: begin
                  if (cnt >= pause_ff) begin
                     ph  = kdee_pkg::PH_REPEAT;
                     iv  = kdee_pkg::IV_PAUSE;
                     cnt = 8'd0;
                  end
               end
               default: begin
                  // A killed key only tracks its history and count.
               end
            endcase
            nxt_rec.hist     = h;
            nxt_rec.count    = cnt;
            nxt_rec.phase    = ph;
            nxt_rec.interval = iv;
         end
         kdee_pkg::CMD_PAUSE: begin
            nxt_rec.phase = kdee_pkg::PH_PAUSE;
            nxt_rec.count = 8'd0;
         end
         kdee_pkg::CMD_KILL: begin
            nxt_rec.phase = kdee_pkg::PH_KILLED;
         end
         default: begin
            // The unused command code leaves the key untouched.
         end
      endcase

      if (!s1_in_range_ff) begin
         ev = kdee_pkg::EV_NONE;
      end
      level = s1_in_range_ff && (nxt_rec.hist == '1);
   end

   assign ram_we = s1_fire && s1_in_range_ff;

   // ------------------------------------------------------------------
   // Pipeline, bypass and valid-bit registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s1_fwd_hit_ff <= 1'b0;
         valid_ff      <= '0;
      end else begin
         if (req_fire) begin
            s1_valid_ff   <= 1'b1;
            s1_fwd_hit_ff <= ram_we && (s1_addr_ff == req_addr);
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (ram_we) begin
            valid_ff[s1_addr_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_key_ff      <= req_key;
         s1_addr_ff     <= req_addr;
         s1_in_range_ff <= req_in_range;
         s1_cmd_ff      <= req_tuser;
         s1_sample_ff   <= req_tdata[4];
      end
      if (ram_we) begin
         fwd_rec_ff <= nxt_rec;
      end
   end

   // Response register: loads from the compute stage, drains on tready.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_kind_ff  <= ev;
         rsp_key_ff   <= s1_key_ff;
         rsp_level_ff <= level;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_level_ff, rsp_key_ff};
   assign rsp_tuser  = rsp_kind_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   `ASSERT_IMPLY(a_stall_blocks_req, rsp_valid_ff && !rsp_tready && s1_valid_ff,
                 !req_tready, "request taken while both stages are full")
   `ASSERT_IMPLY(a_break_is_released, rsp_valid_ff && rsp_kind_ff == kdee_pkg::EV_BREAK,
                 !rsp_level_ff, "break event with a pressed level")
   `ASSERT_IMPLY(a_bypass_entry_valid, s1_valid_ff && s1_fwd_hit_ff,
                 valid_ff[s1_addr_ff], "bypass used for a key that was never written")
   `ASSERT_NEXT(a_write_sets_valid, ram_we, valid_ff[$past(s1_addr_ff)],
                "state write did not mark the key valid")

endmodule

`default_nettype wire
